>>> sv/cfq_pkg.sv
// cfq_pkg: shared types, operation and status codes for the circular FIFO queue.
// Used by circular_fifo_queue; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cfq_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int FIELD_W        = 32;

    localparam logic [1:0] OP_ENQ  = 2'd0;
    localparam logic [1:0] OP_DEQ  = 2'd1;
    localparam logic [1:0] OP_SHOW = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]                operation;
        logic signed [FIELD_W-1:0] data_in;
    } t_in;

    typedef struct packed {
        logic [1:0]                status;
        logic signed [FIELD_W-1:0] data_out;
        logic                      last;
    } t_out;

endpackage

`default_nettype wire

>>> sv/cfq_ram.sv
// cfq_ram: storage array of the circular FIFO queue, one write and one read port,
// registered read data. No package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module cfq_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // hold read data until the next read
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

`default_nettype wire

>>> sv/circular_fifo_queue.sv
// circular_fifo_queue: ring-buffer FIFO with enqueue, dequeue and display operations.
// Depends on cfq_pkg and cfq_ram.
//
//   port group  direction  handshake               payload
//   in          to block   i_in_valid/o_in_ready   i_in_data  (cfq_pkg::t_in)
//   out         from block o_out_valid/i_out_ready o_out_data (cfq_pkg::t_out)
//
// Enqueue and dequeue sustain one item per cycle while the output is not stalled and no
// display runs; a dequeue result passes the RAM read and then the output register.
// Display of N stored elements holds off the input until its last RAM read, one read
// per result through the single read port; an empty queue gives one result.
// Reset is synchronous, active low, and empties the queue; storage is not cleared.
// A stall on the output backs up the read stage and then drops o_in_ready.
`timescale 1ns / 1ps
`default_nettype none

module circular_fifo_queue #(
    parameter int DEPTH      = cfq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = cfq_pkg::DATA_WIDTH_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire cfq_pkg::t_in  i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output cfq_pkg::t_out      o_out_data
);

    import cfq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (DATA_WIDTH > FIELD_W) ? DATA_WIDTH : FIELD_W;
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
    localparam logic [CW-1:0] ONE_CNT  = CW'(1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SHOW = 2'b10
    } t_state;

    function automatic logic [AW-1:0] f_next(input logic [AW-1:0] idx);
        return (idx == LAST_IDX) ? '0 : AW'(idx + 1'b1);
    endfunction

    t_state        r_state, n_state;
    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_pos, n_pos;
    logic [CW-1:0] r_left, n_left;

    // read stage: one result waiting for the RAM data or for the output register
    logic       r_rd_valid;
    logic [1:0] r_rd_status;
    logic       r_rd_last;
    logic       r_rd_mem;

    logic r_out_valid;
    t_out r_out;

    logic       out_free, rd_move, stage_free, in_acc;
    logic       is_empty, is_full;
    logic       push, push_last, push_mem;
    logic [1:0] push_status;
    logic       we, re;
    logic [AW-1:0] raddr;

    logic [XW-1:0]         wr_ext;
    logic [DATA_WIDTH-1:0] wr_data;
    logic [DATA_WIDTH-1:0] rd_data;
    logic [XW-1:0]         rd_ext;

    assign out_free   = !r_out_valid || i_out_ready;
    assign rd_move    = r_rd_valid && out_free;
    assign stage_free = !r_rd_valid || out_free;
    assign o_in_ready = (r_state == S_IDLE) && stage_free;
    assign in_acc     = i_in_valid && o_in_ready;
    assign is_empty   = (r_count == '0);
    assign is_full    = (r_count == FULL_CNT);

    // keep the low DATA_WIDTH bits of the unsigned field value
    assign wr_ext  = XW'($unsigned(i_in_data.data_in));
    assign wr_data = wr_ext[DATA_WIDTH-1:0];
    assign rd_ext  = XW'(rd_data);

    // Only one RAM access is issued per cycle and a dequeue never reads an entry
    // written in the same cycle, so no forwarding is needed.
    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_pos       = r_pos;
        n_left      = r_left;
        push        = 1'b0;
        push_status = ST_OK;
        push_last   = 1'b1;
        push_mem    = 1'b0;
        we          = 1'b0;
        re          = 1'b0;
        raddr       = r_head;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (i_in_data.operation)
                        OP_ENQ: begin
                            push = 1'b1;
                            if (is_full) begin
                                push_status = ST_FULL;
                            end else begin
                                we      = 1'b1;
                                n_tail  = f_next(r_tail);
                                n_count = r_count + 1'b1;
                            end
                        end
                        OP_DEQ: begin
                            push = 1'b1;
                            if (is_empty) begin
                                push_status = ST_EMPTY;
                            end else begin
                                re       = 1'b1;
                                push_mem = 1'b1;
                                n_head   = f_next(r_head);
                                n_count  = r_count - 1'b1;
                            end
                        end
                        OP_SHOW: begin
                            push = 1'b1;
                            if (is_empty) begin
                                push_status = ST_EMPTY;
                            end else begin
                                re        = 1'b1;
                                push_mem  = 1'b1;
                                push_last = (r_count == ONE_CNT);
                                if (r_count != ONE_CNT) begin
                                    n_state = S_SHOW;
                                    n_pos   = f_next(r_head);
                                    n_left  = r_count - 1'b1;
                                end
                            end
                        end
                        default: begin
                            // unused code: drop the item
                        end
                    endcase
                end
            end
            S_SHOW: begin
                if (stage_free) begin
                    push      = 1'b1;
                    re        = 1'b1;
                    raddr     = r_pos;
                    push_mem  = 1'b1;
                    push_last = (r_left == ONE_CNT);
                    n_pos     = f_next(r_pos);
                    n_left    = r_left - 1'b1;
                    if (r_left == ONE_CNT) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    cfq_ram #(
        .DEPTH (DEPTH),
        .WIDTH (DATA_WIDTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_tail),
        .i_wdata (wr_data),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_pos       <= '0;
            r_left      <= '0;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_pos   <= n_pos;
            r_left  <= n_left;
            if (push) begin
                r_rd_valid <= 1'b1;
            end else if (rd_move) begin
                r_rd_valid <= 1'b0;
            end
            if (rd_move) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_rd_status <= push_status;
            r_rd_last   <= push_last;
            r_rd_mem    <= push_mem;
        end
        if (rd_move) begin
            r_out.status   <= r_rd_status;
            r_out.data_out <= r_rd_mem ? rd_ext[FIELD_W-1:0] : '0;
            r_out.last     <= r_rd_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("fill count beyond depth");

    a_show_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHOW) |-> !o_in_ready)
        else $error("input accepted during display");

    a_enq_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_in_data.operation == OP_ENQ) && !is_full)
        |=> (r_count == CW'($past(r_count) + 1'b1)))
        else $error("enqueue did not advance fill count");

    a_read_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        re |=> (r_rd_valid && r_rd_mem))
        else $error("RAM read without a pending result");

endmodule

`default_nettype wire
